// ===== rtl/core/pfc_pkg.sv =====
// Shared types, letter codes and helper functions of the Playfair digraph cipher unit.
package pfc_pkg;

  // Letter codes, A=0 through Z=25.
  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_X = 5'd23;

  // ASCII bounds of the letter ranges.
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5a;
  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_Z = 8'h7a;

  // Key square geometry.
  localparam int SIDE  = 5;
  localparam int CELLS = SIDE * SIDE;
  localparam int FIRST_CELLS = 12;
  localparam int NEXT_CELLS  = 12;

  // Row and column steps for the two directions.
  localparam logic [2:0] STEP_ENC = 3'd1;
  localparam logic [2:0] STEP_DEC = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_SQUARE_FIRST = 2'd0;
  localparam logic [1:0] REG_SQUARE_NEXT  = 2'd1;
  localparam logic [1:0] REG_SQUARE_FINAL = 2'd2;
  localparam logic [1:0] REG_MODE         = 2'd3;

  // Job queue depth.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [CELLS-1:0][4:0] square_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       no_letter;
    logic       out_last;
  } out_item_t;

  // One unit of work for the substitution side: a letter pair or an empty tail mark.
  typedef struct packed {
    logic       empty;
    logic [4:0] a;
    logic [4:0] b;
    logic       dec;
    logic       last;
  } job_t;

  // Add a row or column step modulo the side length; inputs stay below five.
  function automatic logic [2:0] add_mod5(input logic [2:0] v, input logic [2:0] d);
    logic [3:0] s;
    s = {1'b0, v} + {1'b0, d};
    if (s >= 4'(SIDE)) begin
      s = s - 4'(SIDE);
    end
    return s[2:0];
  endfunction

  // Read the cell at a row and column of the square.
  function automatic logic [4:0] cell_at(input square_t sq, input logic [2:0] r,
                                         input logic [2:0] c);
    logic [4:0] idx;
    idx = ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    return sq[idx];
  endfunction

endpackage

// ===== rtl/core/pfc_front.sv =====
// Front end: filters and folds text bytes, inserts and pads X, and forms letter pair jobs.
module pfc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfc_pkg::in_item_t in_data,
  input  logic             mode,
  output logic             push,
  output pfc_pkg::job_t    push_data,
  input  logic             q_full
);

  logic [4:0] prev_letter_r, prev_letter_nxt;
  logic       prev_valid_r, prev_valid_nxt;
  logic [4:0] held_letter_r, held_letter_nxt;
  logic       held_valid_r, held_valid_nxt;
  pfc_pkg::job_t stash_r, stash_nxt;
  logic       stash_v_r, stash_v_nxt;

  logic       acc;
  logic       is_letter;
  logic [4:0] letter;
  logic       ins_x;
  logic [3:0][4:0] lst;
  logic [2:0] cnt;
  logic [1:0] n_push;
  pfc_pkg::job_t job0, job1;

  assign in_stall = stash_v_r | q_full;
  assign acc      = in_valid & ~in_stall;

  // Classify the byte and fold case and J.
  always_comb begin
    is_letter = 1'b0;
    letter    = '0;
    if (in_data.in_byte >= pfc_pkg::CHAR_UC_A && in_data.in_byte <= pfc_pkg::CHAR_UC_Z) begin
      is_letter = 1'b1;
      letter    = 5'(in_data.in_byte - pfc_pkg::CHAR_UC_A);
    end else if (in_data.in_byte >= pfc_pkg::CHAR_LC_A &&
                 in_data.in_byte <= pfc_pkg::CHAR_LC_Z) begin
      is_letter = 1'b1;
      letter    = 5'(in_data.in_byte - pfc_pkg::CHAR_LC_A);
    end
    if (letter == pfc_pkg::LET_J) begin
      letter = pfc_pkg::LET_I;
    end
    ins_x = is_letter & ~mode & prev_valid_r & (prev_letter_r == letter);
  end

  // Build the letter stream: held half pair, inserted X, the letter, and the pad.
  always_comb begin
    lst = '0;
    cnt = '0;
    if (held_valid_r) begin
      lst[0] = held_letter_r;
      cnt    = 3'd1;
    end
    if (ins_x) begin
      lst[cnt[1:0]] = pfc_pkg::LET_X;
      cnt           = cnt + 3'd1;
    end
    if (is_letter) begin
      lst[cnt[1:0]] = letter;
      cnt           = cnt + 3'd1;
    end
    if (in_data.in_last && cnt[0]) begin
      lst[cnt[1:0]] = pfc_pkg::LET_X;
      cnt           = cnt + 3'd1;
    end
  end

  // Turn the stream into at most two jobs.
  always_comb begin
    if (in_data.in_last && cnt == 3'd0) begin
      n_push = 2'd1;
    end else begin
      n_push = cnt[2:1];
    end
    job0.empty = (cnt == 3'd0);
    job0.a     = lst[0];
    job0.b     = lst[1];
    job0.dec   = mode;
    job0.last  = in_data.in_last & (n_push == 2'd1);
    job1.empty = 1'b0;
    job1.a     = lst[2];
    job1.b     = lst[3];
    job1.dec   = mode;
    job1.last  = in_data.in_last;
  end

  // Queue write: a stashed second job goes first.
  always_comb begin
    push      = 1'b0;
    push_data = job0;
    if (stash_v_r) begin
      push      = ~q_full;
      push_data = stash_r;
    end else if (acc && n_push != 2'd0) begin
      push = 1'b1;
    end
  end

  // Next state of the letter history and the stash.
  always_comb begin
    prev_letter_nxt = prev_letter_r;
    prev_valid_nxt  = prev_valid_r;
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    stash_nxt       = stash_r;
    stash_v_nxt     = stash_v_r;
    if (stash_v_r && !q_full) begin
      stash_v_nxt = 1'b0;
    end
    if (acc) begin
      if (n_push == 2'd2) begin
        stash_nxt   = job1;
        stash_v_nxt = 1'b1;
      end
      if (in_data.in_last) begin
        prev_letter_nxt = '0;
        prev_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
        held_valid_nxt  = 1'b0;
      end else begin
        held_valid_nxt  = cnt[0];
        held_letter_nxt = cnt[0] ? lst[{cnt[1], 1'b0}] : 5'd0;
        if (is_letter) begin
          prev_letter_nxt = letter;
          prev_valid_nxt  = 1'b1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_letter_r <= '0;
      prev_valid_r  <= 1'b0;
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      stash_v_r     <= 1'b0;
    end else begin
      prev_letter_r <= prev_letter_nxt;
      prev_valid_r  <= prev_valid_nxt;
      held_letter_r <= held_letter_nxt;
      held_valid_r  <= held_valid_nxt;
      stash_v_r     <= stash_v_nxt;
    end
  end

  // Stashed job payload.
  always_ff @(posedge clk) begin
    stash_r <= stash_nxt;
  end

endmodule

// ===== rtl/core/pfc_queue.sv =====
// Short job queue between the front end and the substitution back end.
module pfc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pfc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output pfc_pkg::job_t pop_data,
  output logic          empty
);

  pfc_pkg::job_t [pfc_pkg::QDEPTH-1:0] slot_r;
  logic [pfc_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pfc_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pfc_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (pfc_pkg::QPTR_W+1)'(pfc_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + (pfc_pkg::QPTR_W)'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + (pfc_pkg::QPTR_W)'(1);
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + (pfc_pkg::QPTR_W+1)'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - (pfc_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/pfc_back.sv =====
// Back end: locates both letters of a pair in the key square and emits the substituted letters.
module pfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pfc_pkg::square_t   square,
  input  logic               q_empty,
  input  pfc_pkg::job_t      q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pfc_pkg::out_item_t out_data
);

  typedef struct packed {
    logic       empty;
    logic       dec;
    logic       last;
  } ctl_t;

  // Match stage.
  logic                      a_v_r;
  ctl_t                      a_ctl_r;
  logic [pfc_pkg::CELLS-1:0] a_ma_r, a_mb_r;
  logic [pfc_pkg::CELLS-1:0] ma, mb;

  // Position stage.
  logic       b_v_r;
  ctl_t       b_ctl_r;
  logic [2:0] b_r1_r, b_c1_r, b_r2_r, b_c2_r;
  logic [2:0] r1, c1, r2, c2;

  // Output stage.
  logic       c_v_r;
  ctl_t       c_ctl_r;
  logic       c_phase_r;
  logic [4:0] c_l0_r, c_l1_r;
  logic [4:0] l0, l1;

  logic out_acc, c_done, c_free, b_free, a_free;

  // Stage handshakes.
  assign out_acc = c_v_r & ~out_stall;
  assign c_done  = out_acc & (c_ctl_r.empty | c_phase_r);
  assign c_free  = ~c_v_r | c_done;
  assign b_free  = ~b_v_r | c_free;
  assign a_free  = ~a_v_r | b_free;
  assign pop     = ~q_empty & a_free;

  // Compare both letters against every cell.
  always_comb begin
    for (int k = 0; k < pfc_pkg::CELLS; k++) begin
      ma[k] = (square[k] == q_data.a);
      mb[k] = (square[k] == q_data.b);
    end
  end

  // First matching cell in row-major order; no match means row 0, column 0.
  always_comb begin
    r1 = '0;
    c1 = '0;
    r2 = '0;
    c2 = '0;
    for (int k = pfc_pkg::CELLS - 1; k >= 0; k--) begin
      if (a_ma_r[k]) begin
        r1 = 3'(k / pfc_pkg::SIDE);
        c1 = 3'(k % pfc_pkg::SIDE);
      end
      if (a_mb_r[k]) begin
        r2 = 3'(k / pfc_pkg::SIDE);
        c2 = 3'(k % pfc_pkg::SIDE);
      end
    end
  end

  // Substitution rules: same row, same column, else rectangle corners.
  always_comb begin
    logic [2:0] d;
    d = b_ctl_r.dec ? pfc_pkg::STEP_DEC : pfc_pkg::STEP_ENC;
    if (b_r1_r == b_r2_r) begin
      l0 = pfc_pkg::cell_at(square, b_r1_r, pfc_pkg::add_mod5(b_c1_r, d));
      l1 = pfc_pkg::cell_at(square, b_r2_r, pfc_pkg::add_mod5(b_c2_r, d));
    end else if (b_c1_r == b_c2_r) begin
      l0 = pfc_pkg::cell_at(square, pfc_pkg::add_mod5(b_r1_r, d), b_c1_r);
      l1 = pfc_pkg::cell_at(square, pfc_pkg::add_mod5(b_r2_r, d), b_c2_r);
    end else begin
      l0 = pfc_pkg::cell_at(square, b_r1_r, b_c2_r);
      l1 = pfc_pkg::cell_at(square, b_r2_r, b_c1_r);
    end
  end

  // Result item from the output stage.
  always_comb begin
    out_valid           = c_v_r;
    out_data.no_letter  = c_ctl_r.empty;
    out_data.out_last   = c_ctl_r.empty | (c_phase_r & c_ctl_r.last);
    if (c_ctl_r.empty) begin
      out_data.out_letter = '0;
    end else if (c_phase_r) begin
      out_data.out_letter = c_l1_r;
    end else begin
      out_data.out_letter = c_l0_r;
    end
  end

  // Stage valid bits and output phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
      c_phase_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= pop;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
      if (c_free) begin
        c_v_r     <= b_v_r;
        c_phase_r <= 1'b0;
      end else if (out_acc) begin
        c_phase_r <= 1'b1;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (pop) begin
      a_ctl_r.empty <= q_data.empty;
      a_ctl_r.dec   <= q_data.dec;
      a_ctl_r.last  <= q_data.last;
      a_ma_r        <= ma;
      a_mb_r        <= mb;
    end
    if (b_free && a_v_r) begin
      b_ctl_r <= a_ctl_r;
      b_r1_r  <= r1;
      b_c1_r  <= c1;
      b_r2_r  <= r2;
      b_c2_r  <= c2;
    end
    if (c_free && b_v_r) begin
      c_ctl_r <= b_ctl_r;
      c_l0_r  <= l0;
      c_l1_r  <= l1;
    end
  end

endmodule

// ===== rtl/core/playfair_digraph_cipher_unit.sv =====
// Top level of the Playfair digraph cipher unit: configuration registers, front end, queue, back end.
// Path: the first result of a byte passes the queue, then the match, position and output stages.
// Throughput: one result per cycle from the output register while out_stall is low; a byte
// that completes two pairs stashes its second job and stalls the input until the queue takes it.
// Reset clears the letter history, the queue and all stages; the key square resets to all A
// and the mode to encrypt. The configuration port is always ready.
module playfair_digraph_cipher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [59:0]        cfg_data
);

  logic [59:0] square_first_r;
  logic [59:0] square_next_r;
  logic [4:0]  square_final_r;
  logic        mode_r;
  pfc_pkg::square_t square;

  logic          push, q_full, pop, q_empty;
  pfc_pkg::job_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_first_r <= '0;
      square_next_r  <= '0;
      square_final_r <= '0;
      mode_r         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfc_pkg::REG_SQUARE_FIRST: square_first_r <= cfg_data;
        pfc_pkg::REG_SQUARE_NEXT:  square_next_r  <= cfg_data;
        pfc_pkg::REG_SQUARE_FINAL: square_final_r <= cfg_data[4:0];
        pfc_pkg::REG_MODE:         mode_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the square into cells in row-major order.
  always_comb begin
    for (int k = 0; k < pfc_pkg::FIRST_CELLS; k++) begin
      square[k] = square_first_r[5*k +: 5];
    end
    for (int k = 0; k < pfc_pkg::NEXT_CELLS; k++) begin
      square[pfc_pkg::FIRST_CELLS + k] = square_next_r[5*k +: 5];
    end
    square[pfc_pkg::CELLS-1] = square_final_r;
  end

  pfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mode      (mode_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  pfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  pfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .square    (square),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sim/playfair_digraph_cipher_unit_tb.sv =====
// Self-checking testbench for the Playfair digraph cipher unit, with its own letter predictor.
`timescale 1ns / 100ps

module playfair_digraph_cipher_unit_tb;

  // Cycles with no accepted item before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  pfc_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  pfc_pkg::out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [59:0] cfg_data;

  // Handshake flags sampled at the falling edge, used at the next rising edge.
  logic      in_take = 1'b0;
  logic      out_take = 1'b0;
  logic      cfg_take = 1'b0;
  pfc_pkg::out_item_t out_seen;

  // Predictor copy of the configuration.
  logic [59:0] key_first;
  logic [59:0] key_next;
  logic [4:0]  key_final;
  logic        dec_mode;

  // Predictor copy of the letter history.
  logic [4:0] last_seen;
  logic       last_seen_ok;
  logic [4:0] half_letter;
  logic       half_ok;

  // Letters produced by the current item, then the letters still awaited from the unit.
  pfc_pkg::out_item_t step_out[$];
  pfc_pkg::out_item_t pending_letters[$];

  int mismatches = 0;
  int items_sent = 0;
  int letters_checked = 0;
  int key_settings = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_kind = 0;
  int stall_span = 0;
  logic [7:0] prev_text_byte = 8'h00;

  playfair_digraph_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample all handshakes while the signals are stable.
  always @(negedge clk) begin
    in_take  = in_valid && !in_stall;
    out_take = out_valid && !out_stall;
    cfg_take = cfg_valid && cfg_ready;
    out_seen = out_data;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cell k of the key square, row-major.
  function automatic logic [4:0] key_cell(input int k);
    if (k < pfc_pkg::FIRST_CELLS) begin
      return key_first[5*k +: 5];
    end else if (k < pfc_pkg::FIRST_CELLS + pfc_pkg::NEXT_CELLS) begin
      return key_next[5*(k-pfc_pkg::FIRST_CELLS) +: 5];
    end
    return key_final;
  endfunction

  // Position of a letter; the first match wins and a missing letter sits at the corner.
  function automatic void find_cell(input logic [4:0] letter, output int row, output int col);
    logic [4:0] want;
    want = (letter == pfc_pkg::LET_J) ? pfc_pkg::LET_I : letter;
    row = 0;
    col = 0;
    for (int k = pfc_pkg::CELLS - 1; k >= 0; k--) begin
      if (key_cell(k) == want) begin
        row = k / pfc_pkg::SIDE;
        col = k % pfc_pkg::SIDE;
      end
    end
  endfunction

  function automatic void push_letter(input logic [4:0] letter);
    pfc_pkg::out_item_t r;
    r.out_letter = letter;
    r.no_letter  = 1'b0;
    r.out_last   = 1'b0;
    step_out.push_back(r);
  endfunction

  // Substitute one pair: row shift, column shift, or swapped rectangle corners.
  function automatic void cipher_pair(input logic [4:0] a, input logic [4:0] b);
    int r1, c1, r2, c2, d;
    d = dec_mode ? int'(pfc_pkg::STEP_DEC) : int'(pfc_pkg::STEP_ENC);
    find_cell(a, r1, c1);
    find_cell(b, r2, c2);
    if (r1 == r2) begin
      push_letter(key_cell(r1*pfc_pkg::SIDE + (c1+d) % pfc_pkg::SIDE));
      push_letter(key_cell(r2*pfc_pkg::SIDE + (c2+d) % pfc_pkg::SIDE));
    end else if (c1 == c2) begin
      push_letter(key_cell(((r1+d) % pfc_pkg::SIDE)*pfc_pkg::SIDE + c1));
      push_letter(key_cell(((r2+d) % pfc_pkg::SIDE)*pfc_pkg::SIDE + c2));
    end else begin
      push_letter(key_cell(r1*pfc_pkg::SIDE + c2));
      push_letter(key_cell(r2*pfc_pkg::SIDE + c1));
    end
  endfunction

  // Either hold the letter as the first half or complete a pair with it.
  function automatic void take_letter(input logic [4:0] letter);
    if (half_ok) begin
      cipher_pair(half_letter, letter);
      half_ok = 1'b0;
      half_letter = '0;
    end else begin
      half_letter = letter;
      half_ok = 1'b1;
    end
  endfunction

  // Work out the results of one accepted text byte and queue them.
  function automatic void predict_cipher(input pfc_pkg::in_item_t it);
    logic       is_alpha;
    logic [4:0] letter;
    pfc_pkg::out_item_t r;
    step_out.delete();
    is_alpha = 1'b0;
    letter = '0;
    if (it.in_byte >= pfc_pkg::CHAR_UC_A && it.in_byte <= pfc_pkg::CHAR_UC_Z) begin
      is_alpha = 1'b1;
      letter = 5'(it.in_byte - pfc_pkg::CHAR_UC_A);
    end else if (it.in_byte >= pfc_pkg::CHAR_LC_A && it.in_byte <= pfc_pkg::CHAR_LC_Z) begin
      is_alpha = 1'b1;
      letter = 5'(it.in_byte - pfc_pkg::CHAR_LC_A);
    end
    if (is_alpha) begin
      if (letter == pfc_pkg::LET_J) begin
        letter = pfc_pkg::LET_I;
      end
      if (!dec_mode && last_seen_ok && last_seen == letter) begin
        take_letter(pfc_pkg::LET_X);
      end
      take_letter(letter);
      last_seen = letter;
      last_seen_ok = 1'b1;
    end
    // End of message: pad an odd leftover, flag the last result, forget history.
    if (it.in_last) begin
      if (half_ok) begin
        take_letter(pfc_pkg::LET_X);
      end
      if (step_out.size() == 0) begin
        r.out_letter = '0;
        r.no_letter  = 1'b1;
        r.out_last   = 1'b1;
        step_out.push_back(r);
      end else begin
        step_out[step_out.size() - 1].out_last = 1'b1;
      end
      last_seen = '0;
      last_seen_ok = 1'b0;
      half_letter = '0;
      half_ok = 1'b0;
    end
    foreach (step_out[i]) begin
      pending_letters.push_back(step_out[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(input string msg);
    mismatches++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin
    pfc_pkg::out_item_t want;
    if (out_take) begin
      letters_checked++;
      if (pending_letters.size() == 0) begin
        report($sformatf("unexpected result letter=%0d no_letter=%0b last=%0b",
                         out_seen.out_letter, out_seen.no_letter, out_seen.out_last));
      end else begin
        want = pending_letters.pop_front();
        if (out_seen.out_letter !== want.out_letter) begin
          report($sformatf("out_letter got %0d want %0d", out_seen.out_letter, want.out_letter));
        end
        if (out_seen.no_letter !== want.no_letter) begin
          report($sformatf("no_letter got %0b want %0b", out_seen.no_letter, want.no_letter));
        end
        if (out_seen.out_last !== want.out_last) begin
          report($sformatf("out_last got %0b want %0b", out_seen.out_last, want.out_last));
        end
      end
    end
  end

  // End the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || in_take || out_take || cfg_take) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Timed out after %0d cycles without a handshake.", HANG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls in spans of random style: none, light, half, or heavy.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_span <= $urandom_range(10, 60);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register; the caller drops cfg_valid after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [59:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_take);
    case (idx)
      pfc_pkg::REG_SQUARE_FIRST: key_first = value;
      pfc_pkg::REG_SQUARE_NEXT:  key_next  = value;
      pfc_pkg::REG_SQUARE_FINAL: key_final = value[4:0];
      default:                   dec_mode  = value[0];
    endcase
  endtask

  // Spare upper bits of the narrow registers carry random junk.
  task automatic set_mode(input logic dec);
    logic [59:0] v;
    v = 60'({$urandom(), $urandom()});
    v[0] = dec;
    write_reg(pfc_pkg::REG_MODE, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_unit(input pfc_pkg::square_t sq, input logic dec);
    logic [59:0] v;
    v = 60'({$urandom(), $urandom()});
    v[4:0] = sq[pfc_pkg::CELLS-1];
    write_reg(pfc_pkg::REG_SQUARE_FIRST, sq[pfc_pkg::FIRST_CELLS-1:0]);
    write_reg(pfc_pkg::REG_SQUARE_NEXT,
              sq[pfc_pkg::FIRST_CELLS+pfc_pkg::NEXT_CELLS-1:pfc_pkg::FIRST_CELLS]);
    write_reg(pfc_pkg::REG_SQUARE_FINAL, v);
    set_mode(dec);
    key_settings++;
  endtask

  // Send one text byte; the sender idles between bursts of random length.
  task automatic send_item(input logic [7:0] b, input logic last);
    pfc_pkg::in_item_t it;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    it.in_byte = b;
    it.in_last = last;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_take);
    items_sent++;
    predict_cipher(it);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      send_item(8'(s[i]), close && (i == s.len() - 1));
    end
  endtask

  // Wait until every expected letter is out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pfc_pkg::square_t square_from_text(input string s);
    pfc_pkg::square_t sq;
    for (int k = 0; k < pfc_pkg::CELLS; k++) begin
      sq[k] = 5'(8'(s[k]) - pfc_pkg::CHAR_UC_A);
    end
    return sq;
  endfunction

  // A proper key square: the 25 letters other than J in random order.
  function automatic pfc_pkg::square_t shuffled_square();
    pfc_pkg::square_t sq;
    logic [4:0] tmp;
    int         n, j;
    n = 0;
    for (int l = 0; l < 26; l++) begin
      if (5'(l) != pfc_pkg::LET_J) begin
        sq[n] = 5'(l);
        n++;
      end
    end
    for (int k = pfc_pkg::CELLS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = sq[k];
      sq[k] = sq[j];
      sq[j] = tmp;
    end
    return sq;
  endfunction

  // A malformed square: duplicates, missing letters and codes above Z.
  function automatic pfc_pkg::square_t noisy_square();
    pfc_pkg::square_t sq;
    for (int k = 0; k < pfc_pkg::CELLS; k++) begin
      sq[k] = 5'($urandom_range(0, 31));
    end
    return sq;
  endfunction

  // Mostly letters of mixed case, with doubled letters, J, punctuation and raw bytes.
  function automatic logic [7:0] text_byte();
    int         pick;
    logic [7:0] b;
    logic [7:0] folded;
    pick = $urandom_range(0, 99);
    folded = prev_text_byte | 8'h20;
    if (pick < 8) begin
      b = 8'($urandom_range(0, 255));
    end else if (pick < 14) begin
      b = 8'($urandom_range(8'h20, 8'h40));
    end else if (pick < 30 && folded >= pfc_pkg::CHAR_LC_A && folded <= pfc_pkg::CHAR_LC_Z) begin
      b = prev_text_byte ^ (($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00);
    end else if (pick < 35) begin
      b = (($urandom_range(0, 1) != 0) ? pfc_pkg::CHAR_UC_A : pfc_pkg::CHAR_LC_A) +
          8'(pfc_pkg::LET_J);
    end else begin
      b = (($urandom_range(0, 1) != 0) ? pfc_pkg::CHAR_UC_A : pfc_pkg::CHAR_LC_A) +
          8'($urandom_range(0, 25));
    end
    prev_text_byte = b;
    return b;
  endfunction

  task automatic send_message(input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      send_item(text_byte(), close && (i == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the square is all A, so every letter maps to the corner.
  task automatic test_reset_square();
    send_text("Ab", 1'b1);
    settle();
  endtask

  // Classic square: case folding, J folding, X between doubled letters,
  // letter range edges, non-letters and padding of an odd tail.
  task automatic test_encrypt_text();
    program_unit(square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ"), 1'b0);
    send_text("HjLlo", 1'b0);
    send_item(8'h00, 1'b0);
    send_text("@[`{", 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("z", 1'b1);
    settle();
  endtask

  // A last byte that yields no letter gives a bare end marker.
  task automatic test_empty_tail();
    send_item(8'h2E, 1'b1);
    settle();
  endtask

  // Decrypt inserts no X, shifts the equal pair along its row and still pads.
  task automatic test_decrypt_pairs();
    set_mode(1'b1);
    send_text("aAb", 1'b1);
    settle();
  endtask

  // Square with codes above Z, duplicate letters and missing letters.
  task automatic test_odd_square();
    pfc_pkg::square_t sq;
    string   s;
    sq = '1;
    s = "QQBCDEFGHIJK";
    for (int k = 0; k < pfc_pkg::NEXT_CELLS; k++) begin
      sq[pfc_pkg::FIRST_CELLS + k] = 5'(8'(s[k]) - pfc_pkg::CHAR_UC_A);
    end
    program_unit(sq, 1'b0);
    send_text("qQxXa", 1'b1);
    settle();
  endtask

  // The pair takes the mode in force when its second letter arrives.
  task automatic test_mode_switch();
    program_unit(square_from_text("PLAYFIREXMBCDGHKNOQSTUVWZ"), 1'b0);
    send_text("k", 1'b0);
    settle();
    set_mode(1'b1);
    send_text("Km", 1'b1);
    settle();
  endtask

  // Random messages under a run of key settings, including both extremes.
  // Some phases leave a message open so it continues under the next setting.
  task automatic test_random_messages();
    pfc_pkg::square_t sq;
    int      sent, len;
    logic    close;
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) begin
        sq = '1;
      end else if (phase == 1) begin
        sq = '0;
      end else if ($urandom_range(0, 3) == 0) begin
        sq = noisy_square();
      end else begin
        sq = shuffled_square();
      end
      program_unit(sq, 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 16) begin
        len = $urandom_range(1, 12);
        if (sent + len >= 16) begin
          close = ($urandom_range(0, 2) != 0);
        end else begin
          close = ($urandom_range(0, 7) != 0);
        end
        send_message(len, close);
        sent += len;
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    key_first = '0;
    key_next  = '0;
    key_final = '0;
    dec_mode  = 1'b0;
    last_seen    = '0;
    last_seen_ok = 1'b0;
    half_letter  = '0;
    half_ok      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_square();
    test_encrypt_text();
    test_empty_tail();
    test_decrypt_pairs();
    test_odd_square();
    test_mode_switch();
    test_random_messages();

    $display("Run covered %0d text bytes under %0d key settings in both directions.",
             items_sent, key_settings);
    $display("Compared %0d result letters; %0d mismatches found.", letters_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
